// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst_n, expr, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/ratg_pkg.sv =====
// ----------------------------------------------------------------------------
// ratg_pkg
// shared types and constants of the recorder tone generator
// ----------------------------------------------------------------------------
package ratg_pkg;

    localparam int DATA_W   = 32;
    localparam int LEN_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int SAMPLE_W = 16;
    localparam int ENV_W    = 9;
    localparam int ACC_W    = 44;
    localparam int SUM_W    = 34;
    localparam int SHIFT_OUT = 27;
    localparam int STEP_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_STEP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH = 2'd3;

    localparam logic [DATA_W-1:0] TONE_STEP_RST = 32'd0;
    localparam logic [DATA_W-1:0] HUM_STEP_RST  = 32'd4473924;
    localparam logic [DATA_W-1:0] ENV_STEP_RST  = 32'd111848;
    localparam logic [LEN_W-1:0]  NOTE_LEN_RST  = 24'd48000;

    localparam logic [63:0] Q30_ONE  = 64'd1073741824;
    localparam logic [63:0] Q30_HALF = 64'd536870912;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [32:0] ENV_ARG_LIMIT = 33'h040000000;

    localparam logic [DATA_W-1:0] OFS_H2  = 32'd1274138960;
    localparam logic [DATA_W-1:0] OFS_H3  = 32'd96582390;
    localparam logic [DATA_W-1:0] OFS_H4  = 32'd1373966180;
    localparam logic [DATA_W-1:0] OFS_HUM = 32'd1845626249;

    localparam logic [ENV_W-1:0] ENV_BASE  = 9'd75;
    localparam logic [ENV_W-1:0] ENV_SCALE = 9'd300;

    // sequencer steps
    localparam logic [STEP_W-1:0] STEP_PHASE_LAST = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ENV_LOAD   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MAC_FIRST  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MAC_LAST   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SCALE      = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        TERM_H1,
        TERM_H2,
        TERM_H3,
        TERM_H4,
        TERM_HUM1,
        TERM_HUM2
    } term_t;

    typedef struct packed {
        logic clear;
        logic accumulate;
        logic scale;
    } mac_ctrl_t;

    // amplitudes, unsigned Q4.12
    function automatic logic [15:0] amp_of(input term_t term);
        logic [15:0] amp;
        case (term)
            TERM_H1:   amp = 16'd56074;
            TERM_H2:   amp = 16'd23437;
            TERM_H3:   amp = 16'd37156;
            TERM_H4:   amp = 16'd1843;
            TERM_HUM1: amp = 16'd1270;
            TERM_HUM2: amp = 16'd1270;
            default:   amp = 16'd0;
        endcase
        return amp;
    endfunction

endpackage

// ===== src/ratg_if.sv =====
// ----------------------------------------------------------------------------
// ratg_if
// valid/ready channels of the recorder tone generator
// ----------------------------------------------------------------------------
interface ratg_in_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink (input valid, input start_req, output ready);
endinterface

interface ratg_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [ratg_pkg::SAMPLE_W-1:0] sample;
    logic                           last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

// ===== src/recorder_additive_tone_generator.sv =====
// ----------------------------------------------------------------------------
// recorder_additive_tone_generator
// additive synthesis of a recorder-like tone with attack envelope
// ----------------------------------------------------------------------------
// Each start_req transfer is taken only while the sequencer is idle. A transfer
// that yields a sample occupies the block through six sine lookups issued one
// per cycle through a single registered rom port, the registered rom read and
// the accumulation of each term, one pass of the shared multiplier for the
// envelope, and a wait until the output register is free to be loaded; no new
// transfer is taken before that. A transfer that yields no sample returns at once.
// The output register holds a finished sample while the next transfer is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module recorder_additive_tone_generator #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int TANH_TABLE_DEPTH = 256,
    parameter int COUNT_WIDTH      = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ratg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ratg_pkg::DATA_W-1:0]        cfg_data,
    ratg_in_if.sink                            in_ch,
    ratg_out_if.source                         out_ch
);

    localparam int LIM_W = ((COUNT_WIDTH > ratg_pkg::LEN_W) ? COUNT_WIDTH : ratg_pkg::LEN_W) + 1;
    localparam logic [LIM_W-1:0] COUNT_CAP = LIM_W'(1) << COUNT_WIDTH;

    // configuration
    logic [ratg_pkg::DATA_W-1:0] tone_step_reg;
    logic [ratg_pkg::DATA_W-1:0] hum_step_reg;
    logic [ratg_pkg::DATA_W-1:0] env_step_reg;
    logic [ratg_pkg::LEN_W-1:0]  note_length_reg;

    // note state
    logic [ratg_pkg::DATA_W-1:0] tone_phase_reg;
    logic [ratg_pkg::DATA_W-1:0] hum_phase_reg;
    logic [ratg_pkg::DATA_W-1:0] env_arg_reg;
    logic [COUNT_WIDTH-1:0]      count_reg;
    logic                        playing_reg;

    ratg_pkg::state_t            state_reg;
    ratg_pkg::state_t            state_next;
    logic [ratg_pkg::STEP_W-1:0] step_reg;

    logic [ratg_pkg::DATA_W-1:0] phase_reg;
    logic [ratg_pkg::DATA_W-1:0] phase_next;
    logic [ratg_pkg::ENV_W-1:0]  env_reg;

    logic                                 out_valid_reg;
    logic signed [ratg_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                 last_reg;

    logic                                 in_xfer;
    logic                                 go;
    logic                                 out_free;
    logic                                 out_load;
    logic                                 in_ready;
    ratg_pkg::mac_ctrl_t                  mac_ctrl;
    ratg_pkg::term_t                      phase_term;
    ratg_pkg::term_t                      amp_term;

    logic [LIM_W-1:0]  note_ext;
    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  count_inc;
    logic              limit_nz;
    logic              is_last;
    logic [32:0]       env_sum;

    logic signed [ratg_pkg::SAMPLE_W-1:0] sine_val;
    logic [15:0]                          tanh_val;
    logic [24:0]                          env_prod;
    logic signed [ratg_pkg::ACC_W-1:0]    acc;
    logic [ratg_pkg::ACC_W-1:0]           acc_mag;
    logic [ratg_pkg::ACC_W-ratg_pkg::SHIFT_OUT-1:0] mag;
    logic signed [ratg_pkg::SAMPLE_W-1:0] sample_calc;

    assign in_xfer  = in_ch.valid && in_ready;
    assign note_ext = LIM_W'(note_length_reg);
    assign limit    = (note_ext > COUNT_CAP) ? COUNT_CAP : note_ext;
    assign limit_nz = (limit != '0);
    assign go       = in_ch.start_req ? limit_nz : playing_reg;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign count_inc = LIM_W'(count_reg) + LIM_W'(1);
    assign is_last  = (count_inc >= limit);
    assign env_sum  = {1'b0, env_arg_reg} + {1'b0, env_step_reg};

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ratg_pkg::ST_IDLE:
            begin
                if (in_ch.valid && go)
                    state_next = ratg_pkg::ST_RUN;
            end
            ratg_pkg::ST_RUN:
            begin
                if (step_reg == ratg_pkg::STEP_SCALE)
                    state_next = ratg_pkg::ST_DONE;
            end
            ratg_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = ratg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ratg_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready            = 1'b0;
        out_load            = 1'b0;
        mac_ctrl.clear      = 1'b0;
        mac_ctrl.accumulate = 1'b0;
        mac_ctrl.scale      = 1'b0;
        case (state_reg)
            ratg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ratg_pkg::ST_RUN:
            begin
                mac_ctrl.clear      = (step_reg < ratg_pkg::STEP_MAC_FIRST);
                mac_ctrl.accumulate = (step_reg >= ratg_pkg::STEP_MAC_FIRST)
                                   && (step_reg <= ratg_pkg::STEP_MAC_LAST);
                mac_ctrl.scale      = (step_reg == ratg_pkg::STEP_SCALE);
            end
            ratg_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_ch.ready = in_ready;

    // harmonic phase for the lookup issued this step
    assign phase_term = ratg_pkg::term_t'(step_reg[2:0]);
    assign amp_term   = ratg_pkg::term_t'(3'(step_reg - ratg_pkg::STEP_MAC_FIRST));

    always_comb
    begin
        case (phase_term)
            ratg_pkg::TERM_H1:   phase_next = tone_phase_reg;
            ratg_pkg::TERM_H2:   phase_next = (tone_phase_reg << 1) + ratg_pkg::OFS_H2;
            ratg_pkg::TERM_H3:   phase_next = tone_phase_reg + (tone_phase_reg << 1)
                                            + ratg_pkg::OFS_H3;
            ratg_pkg::TERM_H4:   phase_next = (tone_phase_reg << 2) + ratg_pkg::OFS_H4;
            ratg_pkg::TERM_HUM1: phase_next = hum_phase_reg + ratg_pkg::OFS_HUM;
            ratg_pkg::TERM_HUM2: phase_next = (hum_phase_reg << 1) + ratg_pkg::OFS_HUM;
            default:             phase_next = '0;
        endcase
    end

    ratg_tables #(
        .SINE_DEPTH (SINE_TABLE_DEPTH),
        .TANH_DEPTH (TANH_TABLE_DEPTH)
    ) u_tables (
        .clk        (clk),
        .sine_phase (phase_reg),
        .env_arg    (env_arg_reg),
        .sine_val   (sine_val),
        .tanh_val   (tanh_val)
    );

    ratg_mac u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .sine_val (sine_val),
        .amp      (ratg_pkg::amp_of(amp_term)),
        .env      (env_reg),
        .acc      (acc)
    );

    assign env_prod = 25'(tanh_val) * 25'(ratg_pkg::ENV_SCALE);

    // truncate toward zero with saturation
    assign acc_mag = acc[ratg_pkg::ACC_W-1] ? (ratg_pkg::ACC_W'(0) - unsigned'(acc))
                                            : unsigned'(acc);
    assign mag     = acc_mag[ratg_pkg::ACC_W-1:ratg_pkg::SHIFT_OUT];

    always_comb
    begin
        if (acc[ratg_pkg::ACC_W-1])
        begin
            if (mag > 17'd32768)
                sample_calc = 16'sh8000;
            else
                sample_calc = signed'(16'(17'd0 - mag));
        end
        else
        begin
            if (mag > 17'd32767)
                sample_calc = 16'sh7fff;
            else
                sample_calc = signed'(mag[15:0]);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ratg_pkg::ST_RUN && step_reg <= ratg_pkg::STEP_PHASE_LAST)
            phase_reg <= phase_next;
        if (state_reg == ratg_pkg::ST_RUN && step_reg == ratg_pkg::STEP_ENV_LOAD)
            env_reg <= ratg_pkg::ENV_BASE + env_prod[24:16];
        if (out_load)
        begin
            sample_reg <= sample_calc;
            last_reg   <= is_last;
        end
    end

    // control, configuration and note state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ratg_pkg::ST_IDLE;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
            tone_step_reg   <= ratg_pkg::TONE_STEP_RST;
            hum_step_reg    <= ratg_pkg::HUM_STEP_RST;
            env_step_reg    <= ratg_pkg::ENV_STEP_RST;
            note_length_reg <= ratg_pkg::NOTE_LEN_RST;
            tone_phase_reg  <= '0;
            hum_phase_reg   <= '0;
            env_arg_reg     <= '0;
            count_reg       <= '0;
            playing_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_xfer)
                step_reg <= '0;
            else if (state_reg == ratg_pkg::ST_RUN)
                step_reg <= step_reg + 1'b1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    ratg_pkg::REG_TONE_STEP:   tone_step_reg   <= cfg_data;
                    ratg_pkg::REG_HUM_STEP:    hum_step_reg    <= cfg_data;
                    ratg_pkg::REG_ENV_STEP:    env_step_reg    <= cfg_data;
                    ratg_pkg::REG_NOTE_LENGTH: note_length_reg <= cfg_data[ratg_pkg::LEN_W-1:0];
                    default:                   tone_step_reg   <= tone_step_reg;
                endcase
            end

            if (in_xfer && in_ch.start_req)
            begin
                tone_phase_reg <= '0;
                hum_phase_reg  <= '0;
                env_arg_reg    <= '0;
                count_reg      <= '0;
                playing_reg    <= limit_nz;
            end
            else if (out_load)
            begin
                if (is_last)
                    playing_reg <= 1'b0;
                else
                begin
                    count_reg      <= count_inc[COUNT_WIDTH-1:0];
                    tone_phase_reg <= tone_phase_reg + tone_step_reg;
                    hum_phase_reg  <= hum_phase_reg + hum_step_reg;
                    env_arg_reg    <= (env_sum > ratg_pkg::ENV_ARG_LIMIT)
                                    ? ratg_pkg::ENV_ARG_LIMIT[31:0] : env_sum[31:0];
                end
            end
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.sample = sample_reg;
    assign out_ch.last   = last_reg;

    `ASSERT_NEXT(a_scale_then_done, clk, rst_n,
        state_reg == ratg_pkg::ST_RUN && step_reg == ratg_pkg::STEP_SCALE,
        state_reg == ratg_pkg::ST_DONE, "sequencer missed the result step")
    `ASSERT_NEXT(a_last_ends_note, clk, rst_n, out_load && is_last,
        !playing_reg && out_ch.valid && out_ch.last, "last sample did not end the note")
    `ASSERT_NEXT(a_idle_tick_no_work, clk, rst_n,
        in_xfer && !in_ch.start_req && !playing_reg,
        state_reg == ratg_pkg::ST_IDLE, "tick after note end started work")
    `ASSERT_HOLDS(a_step_bound, clk, rst_n,
        state_reg != ratg_pkg::ST_RUN || step_reg <= ratg_pkg::STEP_SCALE,
        "step counter ran past the scale step")

endmodule

// ===== src/ratg_tables.sv =====
// ----------------------------------------------------------------------------
// ratg_tables
// sine and tanh lookup roms with registered read data
// ----------------------------------------------------------------------------
module ratg_tables #(
    parameter int SINE_DEPTH = 1024,
    parameter int TANH_DEPTH = 256
) (
    input  logic                                clk,
    input  logic [ratg_pkg::DATA_W-1:0]         sine_phase,
    input  logic [ratg_pkg::DATA_W-1:0]         env_arg,
    output logic signed [ratg_pkg::SAMPLE_W-1:0] sine_val,
    output logic [15:0]                         tanh_val
);

    localparam int SIW = $clog2(SINE_DEPTH);
    localparam int TIW = $clog2(TANH_DEPTH + 1);
    localparam int SPW = 32 + SIW;
    localparam int TPW = 30 + TIW;

    // shift and subtract quotient for rom construction
    function automatic logic [63:0] quot64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den)
            begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [15:0] sine_entry(input logic [63:0] k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        s;
        logic [63:0]        div;
        logic signed [63:0] sum;
        logic               neg;
        x = quot64(k * (64'd2 * ratg_pkg::PI_Q30), 64'(SINE_DEPTH));
        neg = 1'b0;
        if (x >= ratg_pkg::PI_Q30)
        begin
            x = x - ratg_pkg::PI_Q30;
            neg = 1'b1;
        end
        if (x > (ratg_pkg::PI_Q30 >> 1))
            x = ratg_pkg::PI_Q30 - x;
        sum = signed'(x);
        term = x;
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            div = 64'((2 * n) * (2 * n + 1));
            term = quot64(term, div);
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        if (sum > signed'(ratg_pkg::Q30_ONE))
            sum = signed'(ratg_pkg::Q30_ONE);
        s = (64'(sum) * 64'd32767 + ratg_pkg::Q30_HALF) >> 30;
        return neg ? 16'(64'd0 - s) : 16'(s);
    endfunction

    function automatic logic [15:0] tanh_entry(input logic [63:0] k);
        logic [63:0] w;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] t;
        w = quot64(k << 30, 64'(TANH_DEPTH));
        sum = ratg_pkg::Q30_ONE;
        term = ratg_pkg::Q30_ONE;
        for (int n = 1; n <= 20; n++)
        begin
            term = quot64((term * w) >> 30, 64'(n));
            sum = sum + term;
        end
        q = quot64(ratg_pkg::Q30_ONE << 30, sum);
        for (int n = 0; n < 3; n++)
            q = (q * q + ratg_pkg::Q30_HALF) >> 30;
        if (q > ratg_pkg::Q30_ONE)
            q = ratg_pkg::Q30_ONE;
        t = quot64((ratg_pkg::Q30_ONE - q) << 30, ratg_pkg::Q30_ONE + q);
        return 16'((t * 64'd65536 + ratg_pkg::Q30_HALF) >> 30);
    endfunction

    function automatic logic [SINE_DEPTH*16-1:0] build_sine();
        logic [SINE_DEPTH*16-1:0] rom;
        rom = '0;
        for (int k = 0; k < SINE_DEPTH; k++)
            rom[k*16 +: 16] = sine_entry(64'(k));
        return rom;
    endfunction

    function automatic logic [(TANH_DEPTH+1)*16-1:0] build_tanh();
        logic [(TANH_DEPTH+1)*16-1:0] rom;
        rom = '0;
        for (int k = 0; k <= TANH_DEPTH; k++)
            rom[k*16 +: 16] = tanh_entry(64'(k));
        return rom;
    endfunction

    localparam logic [SINE_DEPTH*16-1:0]     SINE_ROM = build_sine();
    localparam logic [(TANH_DEPTH+1)*16-1:0] TANH_ROM = build_tanh();

    logic [SPW-1:0] sine_prod;
    logic [SIW-1:0] sine_idx;
    logic [TPW-1:0] tanh_prod;
    logic [TIW-1:0] tanh_idx;
    logic signed [ratg_pkg::SAMPLE_W-1:0] sine_reg;
    logic [15:0] tanh_reg;

    assign sine_prod = SPW'(sine_phase) * SPW'(SINE_DEPTH);
    assign sine_idx  = sine_prod[32 +: SIW];
    assign tanh_prod = TPW'(env_arg[29:0]) * TPW'(TANH_DEPTH);
    // saturate at argument 4.0
    assign tanh_idx  = (env_arg[31:30] != 2'b00) ? TIW'(TANH_DEPTH) : tanh_prod[30 +: TIW];

    always_ff @(posedge clk)
    begin
        sine_reg <= signed'(SINE_ROM[{sine_idx, 4'b0000} +: 16]);
        tanh_reg <= TANH_ROM[{tanh_idx, 4'b0000} +: 16];
    end

    assign sine_val = sine_reg;
    assign tanh_val = tanh_reg;

endmodule

// ===== src/ratg_mac.sv =====
// ----------------------------------------------------------------------------
// ratg_mac
// shared multiplier with accumulator for harmonic sum and envelope scaling
// ----------------------------------------------------------------------------
module ratg_mac (
    input  logic                                 clk,
    input  ratg_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [ratg_pkg::SAMPLE_W-1:0] sine_val,
    input  logic [15:0]                          amp,
    input  logic [ratg_pkg::ENV_W-1:0]           env,
    output logic signed [ratg_pkg::ACC_W-1:0]    acc
);

    logic signed [ratg_pkg::ACC_W-1:0] acc_reg;
    logic signed [ratg_pkg::ACC_W-1:0] acc_next;
    logic signed [ratg_pkg::SUM_W-1:0] op_a;
    logic signed [16:0]                op_b;
    logic signed [ratg_pkg::SUM_W+16:0] prod;
    logic signed [ratg_pkg::ACC_W-1:0] prod_t;

    always_comb
    begin
        if (ctrl.scale)
        begin
            op_a = acc_reg[ratg_pkg::SUM_W-1:0];
            op_b = signed'({8'b0, env});
        end
        else
        begin
            op_a = ratg_pkg::SUM_W'(sine_val);
            op_b = signed'({1'b0, amp});
        end
    end

    assign prod   = op_a * op_b;
    assign prod_t = signed'(prod[ratg_pkg::ACC_W-1:0]);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (ctrl.accumulate)
            acc_next = acc_reg + prod_t;
        else if (ctrl.scale)
            acc_next = prod_t;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
